// ===== src/lrupr_pkg.sv =====
// Shared types and constants of the LRU page replacement stack.
package lrupr_pkg;

  localparam int FRAMES    = 16;
  localparam int PAGE_BITS = 16;
  localparam int CNT_W     = $clog2(FRAMES + 1);
  localparam int CFG_W     = 5;
  localparam int OCC_W     = 5;
  localparam int TOTAL_W   = 16;

  localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = CFG_W'(16);

  localparam logic CMD_REF   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic                 command;
    logic [PAGE_BITS-1:0] page;
  } lrupr_in_t;

  typedef struct packed {
    logic               fault;
    logic               evicted_valid;
    logic [15:0]        evicted_page;
    logic [OCC_W-1:0]   occupied;
    logic [TOTAL_W-1:0] fault_total;
  } lrupr_out_t;

  // Operation broadcast to every cell for the beat being taken.
  typedef struct packed {
    logic go;
    logic hit;
    logic evict;
    logic append;
  } lrupr_op_t;

  // Position of one cell relative to the current occupancy.
  typedef struct packed {
    logic occ;
    logic top;
    logic slot;
  } lrupr_slot_t;

endpackage

// ===== src/lrupr_cell.sv =====
// One frame of the LRU stack: holds a page, compares it and shifts towards the bottom.
module lrupr_cell (
  input  logic                           clk_i,
  input  logic [lrupr_pkg::PAGE_BITS-1:0] page_i,
  input  logic [lrupr_pkg::PAGE_BITS-1:0] next_page_i,
  input  logic                           seen_i,
  input  lrupr_pkg::lrupr_slot_t         slot_i,
  input  lrupr_pkg::lrupr_op_t           op_i,
  output logic [lrupr_pkg::PAGE_BITS-1:0] page_o,
  output logic                           match_o,
  output logic                           seen_o
);

  logic [lrupr_pkg::PAGE_BITS-1:0] page_q, page_d;
  logic                            shift, load;

  assign match_o = slot_i.occ && (page_q == page_i);
  assign seen_o  = seen_i | match_o;
  assign page_o  = page_q;

  // Everything from the hit frame upwards moves down one place; on an eviction the whole
  // occupied stack does. The top occupied frame then takes the referenced page.
  assign shift = op_i.go && slot_i.occ && !slot_i.top &&
                 ((op_i.hit && seen_o) || op_i.evict);
  assign load  = op_i.go && (((op_i.hit || op_i.evict) && slot_i.top) ||
                             (op_i.append && slot_i.slot));

  always_comb begin
    page_d = page_q;
    if (shift) begin
      page_d = next_page_i;
    end else if (load) begin
      page_d = page_i;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

endmodule

// ===== src/lru_page_replacement.sv =====
// Top level of the LRU page replacement stack: control, row of frame cells and result register.
// Latency: a result is valid in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while the output is not stalled; the match, shift and reload
// of the whole cell row happen in the cycle the beat is accepted, so the next reference sees the updated stack.
// Reset: occupancy and fault total go to zero and the frame limit to 16; frame contents
// are left undefined, as only frames below the occupancy are ever compared or read.
module lru_page_replacement (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lrupr_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  lrupr_pkg::lrupr_in_t         in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output lrupr_pkg::lrupr_out_t        out_data_o
);

  localparam int N = lrupr_pkg::FRAMES;
  localparam int CW = lrupr_pkg::CNT_W;

  logic [lrupr_pkg::CFG_W-1:0]   cfg_q;
  logic [CW-1:0]                 count_q, count_d;
  logic [lrupr_pkg::TOTAL_W-1:0] total_q, total_d;
  logic                          out_vld_q, out_vld_d;
  lrupr_pkg::lrupr_out_t         out_q, out_d;

  logic [CW-1:0]                  limit;
  logic                           accept, hit, at_limit;
  lrupr_pkg::lrupr_op_t           op;
  logic [N-1:0]                   match;
  logic [N:0]                     seen;
  logic [lrupr_pkg::PAGE_BITS-1:0] pages [N];

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_vld_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // A limit of zero behaves as one; anything above the frame count saturates.
  always_comb begin
    if (cfg_q == '0) begin
      limit = CW'(1);
    end else if (32'(cfg_q) > 32'(N)) begin
      limit = CW'(N);
    end else begin
      limit = CW'(cfg_q);
    end
  end

  assign hit      = seen[N];
  assign at_limit = count_q >= limit;

  assign op.go     = accept && (in_data_i.command == lrupr_pkg::CMD_REF);
  assign op.hit    = hit;
  assign op.evict  = !hit && at_limit;
  assign op.append = !hit && !at_limit;

  assign seen[0] = 1'b0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    lrupr_pkg::lrupr_slot_t slot;
    logic [lrupr_pkg::PAGE_BITS-1:0] next_page;

    assign slot.occ  = CW'(i) < count_q;
    assign slot.top  = CW'(i + 1) == count_q;
    assign slot.slot = CW'(i) == count_q;

    if (i == N - 1) begin : g_last
      assign next_page = '0;
    end else begin : g_mid
      assign next_page = pages[i + 1];
    end

    lrupr_cell u_cell (
      .clk_i       (clk_i),
      .page_i      (in_data_i.page),
      .next_page_i (next_page),
      .seen_i      (seen[i]),
      .slot_i      (slot),
      .op_i        (op),
      .page_o      (pages[i]),
      .match_o     (match[i]),
      .seen_o      (seen[i + 1])
    );
  end

  always_comb begin
    count_d   = count_q;
    total_d   = total_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (accept) begin
      out_vld_d = 1'b1;
      if (in_data_i.command == lrupr_pkg::CMD_CLEAR) begin
        count_d = '0;
        total_d = '0;
      end else if (!hit) begin
        if (total_q != '1) begin
          total_d = total_q + 1'b1;
        end
        if (!at_limit) begin
          count_d = count_q + 1'b1;
        end
      end
      out_d.fault         = op.go && !hit;
      out_d.evicted_valid = op.go && op.evict;
      out_d.evicted_page  = (op.go && op.evict) ? 16'(pages[0]) : '0;
      out_d.occupied      = lrupr_pkg::OCC_W'(count_d);
      out_d.fault_total   = total_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q     <= lrupr_pkg::FRAMES_IN_USE_RST;
      count_q   <= '0;
      total_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
      count_q   <= count_d;
      total_q   <= total_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Resident pages are unique, so at most one occupied frame can match.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(match))
    else $error("more than one frame matched the referenced page");

  assert property (@(posedge clk_i) disable iff (!rst_ni) 32'(count_q) <= 32'(N))
    else $error("occupancy exceeds the number of frames");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.evicted_valid |-> out_q.fault)
    else $error("eviction reported without a fault");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.command == lrupr_pkg::CMD_CLEAR |=>
      out_vld_q && out_q.occupied == '0 && out_q.fault_total == '0 && count_q == '0)
    else $error("clear beat did not empty the stack");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && op.go && op.append |=> count_q == $past(count_q) + 1'b1)
    else $error("append did not grow the occupancy");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the LRU page replacement stack, with a built-in LRU predictor.
`timescale 1ns / 1ps

module tb;
  import lrupr_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  // A short run of back-to-back misses that keeps a full stack evicting.
  localparam int ROTATION_REFS = 40;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data  = '0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  lrupr_in_t        in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  lrupr_out_t       out_data;

  // Predictor state: index 0 holds the least recently used page.
  logic [PAGE_BITS-1:0] lru_stack [FRAMES];
  int                   resident_count  = 0;
  logic [TOTAL_W-1:0]   fault_tally     = '0;
  logic [CFG_W-1:0]     frame_limit_cfg = FRAMES_IN_USE_RST;

  lrupr_in_t  pending_refs [$];
  lrupr_out_t expected_outcomes [$];
  lrupr_out_t wanted;

  int unsigned cycle_count = 0;
  int unsigned cfg_writes  = 0;
  int unsigned mismatches  = 0;
  int unsigned burst_left  = 1;
  int unsigned gap_left    = 0;
  logic        in_taken    = 1'b0;
  logic        full_rate   = 1'b0;
  logic [15:0] stall_word  = '1;
  int          limit_plan [13] = '{16, 3, 31, 1, 8, 0, 12, 2, 21, 5, 15, 10, 16};

  lru_page_replacement dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #5 clk = ~clk;

  function automatic int effective_limit(logic [CFG_W-1:0] value);
    int lim;
    lim = int'(value);
    if (lim == 0) lim = 1;
    if (lim > FRAMES) lim = FRAMES;
    return lim;
  endfunction

  // Applies one reference or clear to the predicted stack and returns the outcome.
  function automatic lrupr_out_t lru_access(lrupr_in_t req);
    lrupr_out_t res;
    int         lim;
    int         hit_at;
    res = '0;
    lim = effective_limit(frame_limit_cfg);
    if (req.command == CMD_CLEAR) begin
      resident_count = 0;
      fault_tally    = '0;
    end else begin
      hit_at = -1;
      for (int i = 0; i < resident_count; i++) begin
        if (hit_at < 0 && lru_stack[i] == req.page) hit_at = i;
      end
      if (hit_at >= 0) begin
        for (int i = hit_at + 1; i < resident_count; i++) lru_stack[i-1] = lru_stack[i];
        lru_stack[resident_count-1] = req.page;
      end else begin
        res.fault = 1'b1;
        if (fault_tally != '1) fault_tally++;
        if (resident_count < lim) begin
          lru_stack[resident_count] = req.page;
          resident_count++;
        end else begin
          // The occupancy may exceed a freshly lowered limit; it simply stays put.
          res.evicted_valid = 1'b1;
          res.evicted_page  = lru_stack[0];
          for (int i = 1; i < resident_count; i++) lru_stack[i-1] = lru_stack[i];
          lru_stack[resident_count-1] = req.page;
        end
      end
    end
    res.occupied    = OCC_W'(resident_count);
    res.fault_total = fault_tally;
    return res;
  endfunction

  // Checker and predictor, sampling at the rising edge.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("lru_page_replacement regression: fail");
      $finish;
    end else if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: fault=%0d ev=%0d/%04h occ=%0d total=%0d",
                     out_data.fault, out_data.evicted_valid, out_data.evicted_page,
                     out_data.occupied, out_data.fault_total);
        end else begin
          wanted = expected_outcomes.pop_front();
          if (out_data.fault !== wanted.fault ||
              out_data.evicted_valid !== wanted.evicted_valid ||
              out_data.evicted_page !== wanted.evicted_page ||
              out_data.occupied !== wanted.occupied ||
              out_data.fault_total !== wanted.fault_total) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected fault=%0d ev=%0d/%04h occ=%0d total=%0d,",
                        " got fault=%0d ev=%0d/%04h occ=%0d total=%0d"},
                       wanted.fault, wanted.evicted_valid, wanted.evicted_page,
                       wanted.occupied, wanted.fault_total,
                       out_data.fault, out_data.evicted_valid, out_data.evicted_page,
                       out_data.occupied, out_data.fault_total);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        frame_limit_cfg = cfg_data;
        cfg_writes++;
      end
      if (in_valid && in_ready) expected_outcomes.push_back(lru_access(in_data));
      in_taken <= in_valid && in_ready;
    end
  end

  // Sender: bursts of beats separated by random gaps.
  always @(negedge clk) begin : sender
    logic next_valid;
    next_valid = in_valid && !in_taken;
    if (!next_valid && rst_n) begin
      if (gap_left > 0 && !full_rate) begin
        gap_left--;
      end else if (pending_refs.size() != 0) begin
        in_data <= pending_refs.pop_front();
        next_valid = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    in_valid <= next_valid;
  end

  // Receiver: a rotating stall pattern, periodically reshaped.
  always @(negedge clk) begin : receiver
    logic [15:0] word;
    word = {stall_word[0], stall_word[15:1]};
    if (cycle_count % 128 == 0) begin
      case ($urandom_range(0, 3))
        0: word = '1;
        1: word = 16'($urandom);
        2: word = 16'($urandom & $urandom);
        default: word = 16'h00FF;
      endcase
    end
    stall_word = word;
    out_ready <= full_rate || word[0];
  end

  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (pending_refs.size() != 0 || in_valid || expected_outcomes.size() != 0);
  endtask

  task automatic write_limit(logic [CFG_W-1:0] value);
    int unsigned seen;
    wait_idle();
    seen = cfg_writes;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    while (cfg_writes == seen) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_ref(logic cmd, logic [PAGE_BITS-1:0] page);
    lrupr_in_t item;
    item.command = cmd;
    item.page    = page;
    pending_refs.push_back(item);
  endtask

  // A working set sized around the limit gives a healthy mix of hits and evictions.
  task automatic queue_working_set(logic [CFG_W-1:0] limit_value, int count);
    logic [PAGE_BITS-1:0] hot [24];
    int span;
    int pick;
    span = effective_limit(limit_value) + $urandom_range(0, 4) - 1;
    if (span < 1) span = 1;
    for (int k = 0; k < 24; k++) hot[k] = PAGE_BITS'($urandom);
    if ($urandom_range(0, 1) == 1) hot[0] = '0;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) queue_ref(CMD_CLEAR, PAGE_BITS'($urandom));
      else if (pick < 8) queue_ref(CMD_REF, PAGE_BITS'($urandom));
      else if (pick < 10) queue_ref(CMD_REF, pick[0] ? '1 : '0);
      else queue_ref(CMD_REF, hot[$urandom_range(0, span - 1)]);
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    write_limit(5'd16);
    // Page 0 must miss on an empty stack, then hit once resident.
    queue_ref(CMD_CLEAR, 16'hABCD);
    queue_ref(CMD_REF, 16'h0000);
    queue_ref(CMD_REF, 16'h0000);
    queue_ref(CMD_REF, 16'hFFFF);
    queue_ref(CMD_REF, 16'h8000);
    queue_ref(CMD_REF, 16'h0001);
    queue_ref(CMD_REF, 16'h0000);
    queue_ref(CMD_REF, 16'hFFFF);
    queue_ref(CMD_CLEAR, 16'hFFFF);
    queue_ref(CMD_REF, 16'h0000);

    // A zero limit behaves as a single frame.
    write_limit(5'd0);
    queue_ref(CMD_REF, 16'h0005);
    queue_ref(CMD_REF, 16'h0005);
    queue_ref(CMD_REF, 16'h0007);

    // No clears between phases, so lowered limits meet a fuller stack.
    foreach (limit_plan[p]) begin
      write_limit(CFG_W'(limit_plan[p]));
      queue_working_set(CFG_W'(limit_plan[p]), 100);
    end

    // Seventeen pages in rotation always miss with sixteen frames.
    write_limit(5'd16);
    full_rate = 1'b1;
    queue_ref(CMD_CLEAR, 16'h0000);
    for (int k = 0; k < ROTATION_REFS; k++) queue_ref(CMD_REF, 16'h4000 + 16'(k % 17));
    wait_idle();
    full_rate = 1'b0;
    queue_ref(CMD_REF, 16'h1234);
    queue_ref(CMD_CLEAR, 16'h0000);
    queue_ref(CMD_REF, 16'h1234);

    wait_idle();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && expected_outcomes.size() == 0) begin
      $display("lru_page_replacement regression: pass");
    end else begin
      $display("lru_page_replacement regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/lrupr_pkg.sv
src/lrupr_cell.sv
src/lru_page_replacement.sv
verif/tb.sv
